[hdl/ebq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebq_pkg
// Shared types, constants and the quadrature transition table for the
// encoder and button qualifier.
// ----------------------------------------------------------------------------
package ebq_pkg;

	localparam int STEP_COUNT_BITS_DEF = 16;
	localparam int TIME_BITS_DEF       = 32;

	localparam int TIME_IN_W     = 32;
	localparam int DEBOUNCE_W    = 16;
	localparam int STEPS_OUT_W   = 16;
	localparam int S_TDATA_W     = 40;
	localparam int M_TDATA_W     = 24;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd30;
	localparam logic [1:0]            AB_IDLE        = 2'b11;

	// one poll sample as it sits in the input register
	typedef struct packed {
		logic                 take_press;
		logic                 take_steps;
		logic [TIME_IN_W-1:0] time_ms;
		logic                 button_level;
		logic                 enc_b;
		logic                 enc_a;
	} ebq_sample_t;

	// index is {prev_a, prev_b, cur_a, cur_b}
	function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
		logic signed [1:0] d;
		unique case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
			default: d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

[hdl/ebq_quad.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebq_quad
// Quadrature transition decode, sub-step accumulation and the saturating
// pending detent count, with take-and-clear.
// ----------------------------------------------------------------------------
module ebq_quad #(
	parameter int STEP_COUNT_BITS = ebq_pkg::STEP_COUNT_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   advance,
	input  logic [1:0]                             cur_ab,
	input  logic                                   take_steps,
	output logic signed [ebq_pkg::STEPS_OUT_W-1:0] steps_taken
);
	import ebq_pkg::*;

	localparam int WB = (STEP_COUNT_BITS > STEPS_OUT_W) ? STEP_COUNT_BITS : STEPS_OUT_W;
	localparam logic signed [STEP_COUNT_BITS-1:0] SMAX = {1'b0, {(STEP_COUNT_BITS-1){1'b1}}};
	localparam logic signed [STEP_COUNT_BITS-1:0] SMIN = {1'b1, {(STEP_COUNT_BITS-1){1'b0}}};
	localparam logic signed [STEP_COUNT_BITS-1:0] SONE = STEP_COUNT_BITS'(1);
	localparam logic signed [WB-1:0] OUT_MAX = WB'(32767);
	localparam logic signed [WB-1:0] OUT_MIN = WB'(-32768);

	logic [1:0]                        prev_ab_q;
	logic signed [1:0]                 accum_q;
	logic signed [STEP_COUNT_BITS-1:0] pending_q;

	logic signed [1:0]                 delta;
	logic signed [2:0]                 sum;
	logic signed [1:0]                 accum_nx;
	logic signed [STEP_COUNT_BITS-1:0] pending_nx;
	logic signed [WB-1:0]              pending_ext;

	always_comb begin
		delta      = quad_delta({prev_ab_q, cur_ab});
		sum        = 3'(accum_q) + 3'(delta);
		accum_nx   = sum[1:0];
		pending_nx = pending_q;
		if (sum >= 3'sd2) begin
			accum_nx = 2'sd0;
			if (pending_q != SMAX) pending_nx = pending_q + SONE;
		end else if (sum <= -3'sd2) begin
			accum_nx = 2'sd0;
			if (pending_q != SMIN) pending_nx = pending_q - SONE;
		end
	end

	always_comb begin
		pending_ext = WB'(pending_nx);
		steps_taken = '0;
		if (take_steps) begin
			priority if (pending_ext > OUT_MAX) steps_taken = OUT_MAX[STEPS_OUT_W-1:0];
			else if (pending_ext < OUT_MIN)     steps_taken = OUT_MIN[STEPS_OUT_W-1:0];
			else                                steps_taken = pending_ext[STEPS_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q <= AB_IDLE;
			accum_q   <= '0;
			pending_q <= '0;
		end else if (advance) begin
			prev_ab_q <= cur_ab;
			accum_q   <= accum_nx;
			pending_q <= take_steps ? '0 : pending_nx;
		end
	end

endmodule

[hdl/ebq_debounce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebq_debounce
// Timestamp debounce of the raw button level and press latch with
// take-and-clear.
// ----------------------------------------------------------------------------
module ebq_debounce #(
	parameter int TIME_BITS = ebq_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic                            raw,
	input  logic [TIME_BITS-1:0]            now,
	input  logic [ebq_pkg::DEBOUNCE_W-1:0]  debounce_ms,
	input  logic                            take_press,
	output logic                            press_taken,
	output logic                            stable
);
	import ebq_pkg::*;

	logic                 raw_last_q;
	logic                 deb_q;
	logic [TIME_BITS-1:0] last_q;
	logic                 press_q;

	logic [TIME_BITS-1:0] last_nx;
	logic [TIME_BITS-1:0] elapsed;
	logic                 qualify;
	logic                 press_nx;

	always_comb begin
		last_nx  = (raw != raw_last_q) ? now : last_q;
		elapsed  = now - last_nx;
		qualify  = (elapsed >= TIME_BITS'(debounce_ms)) && (deb_q != raw);
		// stable high to low latches a press
		press_nx = press_q | (qualify & deb_q & ~raw);
		stable   = qualify ? raw : deb_q;
		press_taken = take_press & press_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_last_q <= 1'b1;
			deb_q      <= 1'b1;
			last_q     <= '0;
			press_q    <= 1'b0;
		end else if (advance) begin
			raw_last_q <= raw;
			deb_q      <= stable;
			last_q     <= last_nx;
			press_q    <= take_press ? 1'b0 : press_nx;
		end
	end

endmodule

[hdl/encoder_and_button_qualifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_and_button_qualifier
// Quadrature encoder decoder with timestamp button debounce.
//
// Slave stream s_*: one poll sample per word (encoder levels, raw button,
// millisecond timestamp, take flags). Master stream m_*: exactly one result
// word per sample, in order. cfg_*: write of debounce_ms, always ready; write
// only while the block is idle.
// Path: a sample accepted on s_* passes the input register, then the result
// register, before its result shows on m_*.
// Throughput: one sample per cycle while m_tready is high; the decode, count and
// debounce update is a single pass of logic between the input and result registers.
// Stall: when m_tready is low the result holds, one more sample is taken into
// the input register, then s_tready drops until the result is taken.
// Reset: encoder previous pair both high, button raw and debounced released,
// no pending steps or press, debounce_ms = 30.
// ----------------------------------------------------------------------------
module encoder_and_button_qualifier #(
	parameter int STEP_COUNT_BITS = ebq_pkg::STEP_COUNT_BITS_DEF,
	parameter int TIME_BITS       = ebq_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// enc_a, enc_b, button_level, time_ms[31:0], take_steps, take_press, zero fill
	input  logic [ebq_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// steps_out[15:0], press_out, button_stable, zero fill
	output logic [ebq_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [ebq_pkg::DEBOUNCE_W-1:0]  cfg_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready
);
	import ebq_pkg::*;

	localparam int SAMPLE_W = $bits(ebq_sample_t);

	logic [DEBOUNCE_W-1:0]   debounce_q;
	ebq_sample_t             sample_s1;
	logic                    valid_s1;
	logic                    advance;

	logic signed [STEPS_OUT_W-1:0] steps_taken;
	logic                          press_taken;
	logic                          stable;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_q <= cfg_data;
		end
	end

	// advance the held sample whenever the result slot is free or being taken
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= ebq_sample_t'(s_tdata[SAMPLE_W-1:0]);
		end
	end

	ebq_quad #(
		.STEP_COUNT_BITS(STEP_COUNT_BITS)
	) u_quad (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.cur_ab      ({sample_s1.enc_a, sample_s1.enc_b}),
		.take_steps  (sample_s1.take_steps),
		.steps_taken (steps_taken)
	);

	ebq_debounce #(
		.TIME_BITS(TIME_BITS)
	) u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.raw         (sample_s1.button_level),
		.now         (TIME_BITS'(sample_s1.time_ms)),
		.debounce_ms (debounce_q),
		.take_press  (sample_s1.take_press),
		.press_taken (press_taken),
		.stable      (stable)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {{(M_TDATA_W - STEPS_OUT_W - 2){1'b0}}, stable, press_taken, steps_taken};
		end
	end

`ifndef SYNTHESIS
	a_steps_zero_untaken: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !sample_s1.take_steps |=> m_tdata[STEPS_OUT_W-1:0] == '0)
		else $error("steps_out nonzero without take_steps");

	a_press_zero_untaken: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !sample_s1.take_press |=> !m_tdata[STEPS_OUT_W])
		else $error("press_out set without take_press");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while both stages are full");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced sample produced no result");
`endif

endmodule
